[src/fsn_pkg.sv]
// Types, constants and the character map for the 8.3 short name generator.
// No dependencies.
package fsn_pkg;

    localparam int unsigned NAME_LEN = 11;
    localparam int unsigned BASE_LEN = 8;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [1:0] {
        PH_BASE = 2'd0,
        PH_SKIP = 2'd1,
        PH_EXT  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DOT  = 2'd1,
        ST_COLL = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic       cmd;
        logic [7:0] name_char;
        logic       name_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] short_char;
        logic [3:0] position;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // Per-cell control: clear wins over load, load over rotate.
    typedef struct packed {
        logic       clr;
        logic       ld;
        logic       sh;
        logic [7:0] d;
    } t_cell_ctl;

    function automatic logic [7:0] map_char(input logic [7:0] c_in);
        logic [7:0] c;
        logic [7:0] r;
        c = c_in;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
        r = CH_UNDER;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)) r = c;
        case (c)
            8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
            8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26: r = c;
            default: ;
        endcase
        return r;
    endfunction

endpackage

[src/fsn_cell.sv]
// One byte cell of the short name buffer; rotates toward its neighbor.
// Depends on fsn_pkg.
module fsn_cell import fsn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_next,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_byte <= CH_SPACE;
        end else if (i_ctl.ld) begin
            r_byte <= i_ctl.d;
        end else if (i_ctl.sh) begin
            r_byte <= i_next;
        end
    end

    assign o_byte = r_byte;

endmodule

[src/fat_short_name_generator_core.sv]
// Top level of the 8.3 short name generator: control, name table, cell row.
// Depends on fsn_pkg and fsn_cell.
//
// Usage:
//  Input channel (i_in_valid / o_in_stall, payload i_in_data): one long-name
//  character per transfer; cmd=1 clears the stored name table. The transfer
//  with name_end set starts the finish sequence, during which o_in_stall is
//  high.
//  Finish: a check step, then a collision scan over the table, which reads one
//  stored byte per cycle while the 11-cell buffer rotates past it, restarted
//  after each ~N retry. Then the 11 bytes are emitted (and written to the
//  table) one per cycle while the output is not stalled.
//  Skipped dot entries, a full table and too many collisions give a single
//  result transfer instead.
//  Output channel (o_out_valid / i_out_stall, payload o_out_data): a held
//  result stays in place while i_out_stall is high; emission pauses.
//  Config: i_cfg_we with i_cfg_wdata writes in_root; write only when idle.
//  Reset (synchronous, i_rst_n low): empty table, blank buffer, in_root 0,
//  no result pending. The table memory itself is not cleared.
module fat_short_name_generator_core import fsn_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    localparam int unsigned DEPTH = MAX_ENTRIES * NAME_LEN;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_BUILD, S_FIN, S_SCAN, S_DRAIN, S_EMIT, S_SINGLE
    } t_state;

    t_state     r_state;
    logic       r_in_root;
    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_base;          // entry_count * 11
    logic [CW-1:0] r_count;
    logic [3:0] r_k;                // byte index within a name
    logic [3:0] r_fill;
    t_phase     r_phase;
    logic       r_strip;
    logic [1:0] r_prun;
    logic [3:0] r_tens, r_ones;     // retry number, decimal
    logic       r_cv, r_cfirst, r_eq;
    logic [7:0] r_head_d;
    logic [1:0] r_status;
    logic       r_ovalid;
    t_out_item  r_odata;

    t_cell_ctl  cctl [NAME_LEN];
    logic [7:0] cbyte [NAME_LEN];

    // cell row
    for (genvar g = 0; g < NAME_LEN; g++) begin : g_cell
        fsn_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (cctl[g]),
            .i_next (cbyte[(g + 1) % NAME_LEN]),
            .o_byte (cbyte[g])
        );
    end

    logic       in_xfer, slot_free;
    logic [7:0] c;
    logic [7:0] mc;
    logic [3:0] n_fill;
    t_phase     n_phase;
    logic       n_strip;
    logic [1:0] n_prun;
    logic       wr_en;
    logic [3:0] wr_idx;
    logic       match, clash;
    logic [3:0] n_tens, n_ones;
    logic       n_lt9, n_99;
    logic [AW-1:0] wr_addr;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign slot_free = !r_ovalid || !i_out_stall;
    assign c         = i_in_data.name_char;
    assign mc        = map_char(c);
    assign match     = (r_rdata == r_head_d);
    assign clash     = (r_cfirst ? 1'b1 : r_eq) && match;
    assign wr_addr   = r_base + AW'(r_k);

    // next retry number
    always_comb begin
        if (r_ones == 4'd9) begin
            n_ones = 4'd0;
            n_tens = r_tens + 4'd1;
        end else begin
            n_ones = r_ones + 4'd1;
            n_tens = r_tens;
        end
        n_lt9 = (n_tens == 4'd0) && (n_ones < 4'd9);
        n_99  = (n_tens == 4'd9) && (n_ones == 4'd9);
    end

    // character intake
    always_comb begin
        n_fill  = r_fill;
        n_phase = r_phase;
        n_strip = r_strip;
        wr_en   = 1'b0;
        wr_idx  = r_fill;
        if (c == CH_DOT) n_prun = (r_prun < 2'd3) ? r_prun + 2'd1 : 2'd3;
        else             n_prun = 2'd3;
        case (r_phase)
            PH_BASE: begin
                if (r_fill < 4'(BASE_LEN)) begin
                    if (c == CH_SPACE) begin
                    end else if (c == CH_DOT) begin
                        if (!r_strip) begin
                            n_fill  = 4'(BASE_LEN);
                            n_phase = PH_EXT;
                        end
                    end else begin
                        n_strip = 1'b0;
                        wr_en   = 1'b1;
                        n_fill  = r_fill + 4'd1;
                    end
                end else begin
                    n_fill  = 4'(BASE_LEN);
                    n_phase = (c == CH_DOT) ? PH_EXT : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (c == CH_DOT) n_phase = PH_EXT;
            end
            PH_EXT: begin
                if (c == CH_DOT) begin
                    n_phase = PH_DONE;
                end else if (r_fill < 4'(NAME_LEN)) begin
                    wr_en  = 1'b1;
                    n_fill = r_fill + 4'd1;
                    if (n_fill >= 4'(NAME_LEN)) n_phase = PH_DONE;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // cell control
    always_comb begin
        for (int i = 0; i < NAME_LEN; i++) cctl[i] = '0;
        case (r_state)
            S_BUILD: begin
                if (in_xfer) begin
                    if (i_in_data.cmd) begin
                        for (int i = 0; i < NAME_LEN; i++) cctl[i].clr = 1'b1;
                    end else if (wr_en) begin
                        for (int i = 0; i < NAME_LEN; i++) begin
                            if (wr_idx == 4'(i)) begin
                                cctl[i].ld = 1'b1;
                                cctl[i].d  = mc;
                            end
                        end
                    end
                end
            end
            S_FIN: begin
                if ((r_prun == 2'd1 || r_prun == 2'd2) && !r_in_root) begin
                    for (int i = 0; i < NAME_LEN; i++) cctl[i].clr = 1'b1;
                    cctl[0].clr = 1'b0;
                    cctl[0].ld  = 1'b1;
                    cctl[0].d   = CH_DOT;
                    if (r_prun == 2'd2) begin
                        cctl[1].clr = 1'b0;
                        cctl[1].ld  = 1'b1;
                        cctl[1].d   = CH_DOT;
                    end
                end
            end
            S_SCAN: begin
                for (int i = 0; i < NAME_LEN; i++) cctl[i].sh = 1'b1;
            end
            S_DRAIN: begin
                if (clash && !n_99) begin
                    if (n_lt9) begin
                        cctl[6].ld = 1'b1;
                        cctl[6].d  = CH_TILDE;
                        cctl[7].ld = 1'b1;
                        cctl[7].d  = CH_ZERO + {4'd0, n_ones};
                    end else begin
                        cctl[5].ld = 1'b1;
                        cctl[5].d  = CH_TILDE;
                        cctl[6].ld = 1'b1;
                        cctl[6].d  = CH_ZERO + {4'd0, n_tens};
                        cctl[7].ld = 1'b1;
                        cctl[7].d  = CH_ZERO + {4'd0, n_ones};
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    for (int i = 0; i < NAME_LEN; i++) begin
                        cctl[i].sh  = 1'b1;
                        cctl[i].clr = (r_k == 4'(NAME_LEN - 1));
                    end
                end
            end
            S_SINGLE: begin
                if (slot_free) begin
                    for (int i = 0; i < NAME_LEN; i++) cctl[i].clr = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // table memory: one read and one write port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_addr];
        if (r_state == S_EMIT && slot_free) mem[wr_addr] <= cbyte[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_BUILD;
            r_in_root <= 1'b0;
            r_addr    <= '0;
            r_base    <= '0;
            r_count   <= '0;
            r_k       <= '0;
            r_fill    <= '0;
            r_phase   <= PH_BASE;
            r_strip   <= 1'b1;
            r_prun    <= '0;
            r_tens    <= '0;
            r_ones    <= '0;
            r_cv      <= 1'b0;
            r_cfirst  <= 1'b0;
            r_eq      <= 1'b0;
            r_status  <= ST_OK;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_in_root <= i_cfg_wdata;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;

            // compare pipeline, in step with the registered read data
            r_cv     <= (r_state == S_SCAN);
            r_cfirst <= (r_k == 4'd0);
            r_head_d <= cbyte[0];
            if (r_cv) r_eq <= clash;

            case (r_state)
                S_BUILD: begin
                    if (in_xfer) begin
                        if (i_in_data.cmd) begin
                            r_count <= '0;
                            r_base  <= '0;
                            r_fill  <= '0;
                            r_phase <= PH_BASE;
                            r_strip <= 1'b1;
                            r_prun  <= '0;
                        end else begin
                            r_fill  <= n_fill;
                            r_phase <= n_phase;
                            r_strip <= n_strip;
                            r_prun  <= n_prun;
                            if (i_in_data.name_end) r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_addr <= '0;
                    r_k    <= '0;
                    r_tens <= '0;
                    r_ones <= '0;
                    if ((r_prun == 2'd1 || r_prun == 2'd2) && r_in_root) begin
                        r_status <= ST_DOT;
                        r_state  <= S_SINGLE;
                    end else if (r_count == CW'(MAX_ENTRIES)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_SINGLE;
                    end else if (r_base == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_k == 4'(NAME_LEN - 1)) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_DRAIN: begin
                    if (clash) begin
                        r_tens <= n_tens;
                        r_ones <= n_ones;
                        if (n_99) begin
                            r_status <= ST_COLL;
                            r_state  <= S_SINGLE;
                        end else begin
                            r_addr  <= '0;
                            r_state <= S_SCAN;
                        end
                    end else if (r_addr == r_base) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_ovalid            <= 1'b1;
                        r_odata.short_char  <= cbyte[0];
                        r_odata.position    <= r_k;
                        r_odata.status      <= ST_OK;
                        r_odata.last        <= (r_k == 4'(NAME_LEN - 1));
                        if (r_k == 4'(NAME_LEN - 1)) begin
                            r_k     <= '0;
                            r_count <= r_count + CW'(1);
                            r_base  <= r_base + AW'(NAME_LEN);
                            r_fill  <= '0;
                            r_phase <= PH_BASE;
                            r_strip <= 1'b1;
                            r_prun  <= '0;
                            r_state <= S_BUILD;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                S_SINGLE: begin
                    if (slot_free) begin
                        r_ovalid           <= 1'b1;
                        r_odata.short_char <= '0;
                        r_odata.position   <= '0;
                        r_odata.status     <= r_status;
                        r_odata.last       <= 1'b1;
                        r_fill             <= '0;
                        r_phase            <= PH_BASE;
                        r_strip            <= 1'b1;
                        r_prun             <= '0;
                        r_state            <= S_BUILD;
                    end
                end
                default: r_state <= S_BUILD;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_BUILD);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
